FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file dsd_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, quiet during reset.
`define DSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types for the shift-subtract divider: controller state, command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture operands of an accepted transaction
        logic step;   // one restoring-division iteration
        logic emit;   // move result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_zero;  // incoming divisor is zero
        logic out_busy;  // output register holds a stalled result
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/dsd_ctrl.sv
// ----------------------------------------------------------------------------
// dsd_ctrl
// Sequencer for the divider: accepts a transaction, runs WIDTH iterations of
// the datapath (none for zero divisor) and fills the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_ctrl #(
    parameter int WIDTH = 31
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    input  dsd_pkg::status_t status,
    output dsd_pkg::cmd_t    cmd
);
    import dsd_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          accept;
    logic          last;

    assign accept = in_valid && !in_stall;
    assign last   = (cnt_reg == LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.div_zero ? ST_FINISH : ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_BUSY:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = !status.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // iteration counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dsd_datapath.sv
// ----------------------------------------------------------------------------
// dsd_datapath
// Restoring division datapath: partial remainder and quotient shift registers,
// one trial subtract per step, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_datapath #(
    parameter int WIDTH = 31
) (
    input  wire              clk,
    input  wire              rst_n,
    input  dsd_pkg::cmd_t    cmd,
    output dsd_pkg::status_t status,
    input  wire [WIDTH-1:0]  dividend,
    input  wire [WIDTH-1:0]  divisor,
    output logic             out_valid,
    input  wire              out_stall,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output logic             divide_by_zero
);
    import dsd_pkg::*;

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic             dz_reg, dz_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] q_out_reg, q_out_next;
    logic [WIDTH-1:0] r_out_reg, r_out_next;
    logic             dz_out_reg, dz_out_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH+1:0] diff;
    logic             fits;

    assign status.div_zero = (divisor == '0);
    assign status.out_busy = out_valid_reg && out_stall;

    // trial subtract: shift next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = !diff[WIDTH+1];

    // working registers
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        dz_next  = dz_reg;
        if (cmd.load)
        begin
            // zero divisor skips the iterations: result is staged directly
            rem_next = status.div_zero ? dividend : '0;
            quo_next = status.div_zero ? '0 : dividend;
            den_next = divisor;
            dz_next  = status.div_zero;
        end
        else if (cmd.step)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        q_out_next     = q_out_reg;
        r_out_next     = r_out_reg;
        dz_out_next    = dz_out_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            q_out_next     = quo_reg;
            r_out_next     = rem_reg;
            dz_out_next    = dz_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        den_reg    <= den_next;
        dz_reg     <= dz_next;
        q_out_reg  <= q_out_next;
        r_out_reg  <= r_out_next;
        dz_out_reg <= dz_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign quotient       = q_out_reg;
    assign remainder      = r_out_reg;
    assign divide_by_zero = dz_out_reg;

endmodule

`default_nettype wire

FILE: rtl/doubling_subtract_divider.sv
// ----------------------------------------------------------------------------
// doubling_subtract_divider
// Unsigned integer divider returning quotient, remainder and a zero-divisor
// flag for each transaction.
// ----------------------------------------------------------------------------
// One transaction is divided at a time by a restoring shift-subtract loop that
// retires one quotient bit per cycle: after acceptance the subtract unit runs
// WIDTH iterations, then the result is handed to the output register and the
// divider returns to idle for the next acceptance. A zero divisor skips the
// loop; it returns quotient 0, remainder equal to the dividend and
// divide_by_zero set. The result sits in an output register, so a new
// transaction is accepted while an earlier result is still stalled; a
// finished result waits for that register.
`default_nettype none

module doubling_subtract_divider #(
    parameter int WIDTH = 31
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    input  wire [WIDTH-1:0]  dividend,
    input  wire [WIDTH-1:0]  divisor,
    output logic             out_valid,
    input  wire              out_stall,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output logic             divide_by_zero
);
    import dsd_pkg::*;

    cmd_t    cmd;
    status_t status;

    dsd_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dsd_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .dividend       (dividend),
        .divisor        (divisor),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero)
    );

endmodule

`default_nettype wire

FILE: rtl/dsd_checker.sv
// ----------------------------------------------------------------------------
// dsd_checker
// Port-level checks for the divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dsd_checker #(
    parameter int WIDTH = 31
) (
    input wire             clk,
    input wire             rst_n,
    input wire             in_valid,
    input wire             in_stall,
    input wire             out_valid,
    input wire             out_stall,
    input wire [WIDTH-1:0] quotient,
    input wire [WIDTH-1:0] remainder,
    input wire             divide_by_zero
);

    // whole result payload, for stability checks
    wire [2*WIDTH:0] result_bus = {quotient, remainder, divide_by_zero};

    // a stalled result is not dropped
    `DSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a stalled result does not change
    `DSD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(result_bus), "result moved")

    // one transaction at a time: accepting closes the input
    `DSD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

    // a new result appears only as the divider goes back to idle
    `DSD_ASSERT_IMPL(a_idle_on_result, $rose(out_valid), !in_stall, "result without idle input")

    // zero divisor reports a zero quotient
    `DSD_ASSERT_IMPL(a_dz_quotient, out_valid && divide_by_zero, quotient == '0, "nonzero quotient")

endmodule

bind doubling_subtract_divider dsd_checker #(.WIDTH(WIDTH)) u_dsd_checker (.*);

`default_nettype wire
